// ----- rtl/core/pvtc_pkg.sv -----
// types and constants for the pin locked vote tally controller
package pvtc_pkg;

    localparam int PIN_DIGITS_DEF = 5;
    localparam int TALLY_BITS_DEF = 16;

    localparam int PIN_CODE_BITS  = 20;
    localparam int COUNT_BITS     = 3;
    localparam int TOTAL_BITS     = 16;

    localparam logic [PIN_CODE_BITS-1:0] PIN_CODE_RESET = 20'h80085;

    localparam logic [3:0] KEY_ONE        = 4'd1;
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_A          = 4'd10;
    localparam logic [3:0] KEY_D          = 4'd13;
    localparam logic [3:0] KEY_HASH       = 4'd14;
    localparam logic [3:0] KEY_STAR       = 4'd15;

    typedef enum logic [1:0] {
        MODE_PIN   = 2'd0,
        MODE_VOTE  = 2'd1,
        MODE_ADMIN = 2'd2,
        MODE_WAIT  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IGNORED  = 4'd0,
        ST_DIGIT    = 4'd1,
        ST_PIN_OK   = 4'd2,
        ST_PIN_BAD  = 4'd3,
        ST_SELECTED = 4'd4,
        ST_VOTED    = 4'd5,
        ST_INVALID  = 4'd6,
        ST_ADMIN    = 4'd7,
        ST_TOTALS   = 4'd8,
        ST_RESTART  = 4'd9
    } status_t;

endpackage

// ----- rtl/core/pin_locked_vote_tally_controller.sv -----
// pin locked vote tally controller: key word in, one status word out
// path: an accepted key word is held in the input register, and its status word is then loaded into the result register
// throughput: one key word per cycle while the result register is not stalled, input register then result register
// a stalled result register holds the input side only once the input register is full
// reset: asynchronous, clears mode, pin entry, selection and tallies; pin code back to 80085
module pin_locked_vote_tally_controller #(
    parameter int PIN_DIGITS = pvtc_pkg::PIN_DIGITS_DEF,
    parameter int TALLY_BITS = pvtc_pkg::TALLY_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pin_code_we,
    input  logic [pvtc_pkg::PIN_CODE_BITS-1:0] pin_code,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [3:0]                         key,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [3:0]                         status,
    output logic [1:0]                         mode_now,
    output logic [pvtc_pkg::COUNT_BITS-1:0]    digits_entered,
    output logic [2:0]                         chosen,
    output logic [pvtc_pkg::TOTAL_BITS-1:0]    total_a,
    output logic [pvtc_pkg::TOTAL_BITS-1:0]    total_b,
    output logic [pvtc_pkg::TOTAL_BITS-1:0]    total_c,
    output logic [pvtc_pkg::TOTAL_BITS-1:0]    total_d
);

    localparam int PIN_BITS = 4 * PIN_DIGITS;
    localparam int CB       = pvtc_pkg::COUNT_BITS;
    localparam int TB       = pvtc_pkg::TOTAL_BITS;

    logic [pvtc_pkg::PIN_CODE_BITS-1:0] pin_code_reg;

    logic                  in_valid_reg;
    logic [3:0]            key_reg;
    logic                  out_valid_reg;

    pvtc_pkg::mode_t       mode_reg, mode_next;
    logic [PIN_BITS-1:0]   entry_reg, entry_next;
    logic [CB-1:0]         count_reg, count_next;
    logic [2:0]            sel_reg, sel_next;
    logic [TALLY_BITS-1:0] tally_reg [4];
    logic [TALLY_BITS-1:0] tally_next [4];

    pvtc_pkg::status_t     status_next;
    logic                  tally_inc;

    logic [3:0]            status_reg;
    logic [1:0]            mode_out_reg;
    logic [CB-1:0]         count_out_reg;
    logic [2:0]            sel_out_reg;
    logic [TB-1:0]         total_reg [4];

    logic                  advance;
    logic                  fire;

    logic                  is_digit;
    logic                  is_cand;
    logic [PIN_BITS-1:0]   entry_shift;
    logic [CB:0]           count_inc;
    logic                  last_digit;
    logic [PIN_BITS+pvtc_pkg::PIN_CODE_BITS-1:0] pin_ext;
    logic                  pin_match;
    logic [1:0]            sel_idx;
    logic [TALLY_BITS-1:0] sel_tally;
    logic [TALLY_BITS+TB-1:0] tally_ext [4];

    // handshake
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    // shared decode
    assign is_digit    = key_reg <= pvtc_pkg::KEY_LAST_DIGIT;
    assign is_cand     = (key_reg >= pvtc_pkg::KEY_A) && (key_reg <= pvtc_pkg::KEY_D);
    assign entry_shift = PIN_BITS'({entry_reg, key_reg});
    assign count_inc   = {1'b0, count_reg} + (CB+1)'(1);
    assign last_digit  = count_inc == (CB+1)'(PIN_DIGITS);
    assign pin_ext     = {{PIN_BITS{1'b0}}, pin_code_reg};
    assign pin_match   = entry_shift == pin_ext[PIN_BITS-1:0];
    assign sel_idx     = 2'(sel_reg - 3'd1);
    assign sel_tally   = tally_reg[sel_idx];

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            pvtc_pkg::MODE_PIN:
            begin
                if (is_digit && last_digit && pin_match)
                    mode_next = pvtc_pkg::MODE_VOTE;
            end
            pvtc_pkg::MODE_VOTE:
            begin
                if (key_reg == pvtc_pkg::KEY_HASH && sel_reg != 3'd0)
                    mode_next = pvtc_pkg::MODE_WAIT;
                else if (key_reg == pvtc_pkg::KEY_STAR)
                    mode_next = pvtc_pkg::MODE_ADMIN;
            end
            pvtc_pkg::MODE_ADMIN:
            begin
                if (is_digit && last_digit)
                    mode_next = pin_match ? pvtc_pkg::MODE_WAIT : pvtc_pkg::MODE_VOTE;
            end
            pvtc_pkg::MODE_WAIT:
            begin
                if (key_reg == pvtc_pkg::KEY_ONE)
                    mode_next = pvtc_pkg::MODE_VOTE;
            end
            default:
            begin
                mode_next = pvtc_pkg::MODE_PIN;
            end
        endcase
    end

    // status and data updates
    always_comb
    begin
        status_next = pvtc_pkg::ST_IGNORED;
        entry_next  = entry_reg;
        count_next  = count_reg;
        sel_next    = sel_reg;
        tally_inc   = 1'b0;
        case (mode_reg)
            pvtc_pkg::MODE_PIN, pvtc_pkg::MODE_ADMIN:
            begin
                if (is_digit)
                begin
                    if (last_digit)
                    begin
                        entry_next = '0;
                        count_next = '0;
                        if (!pin_match)
                            status_next = pvtc_pkg::ST_PIN_BAD;
                        else if (mode_reg == pvtc_pkg::MODE_PIN)
                            status_next = pvtc_pkg::ST_PIN_OK;
                        else
                            status_next = pvtc_pkg::ST_TOTALS;
                    end
                    else
                    begin
                        entry_next  = entry_shift;
                        count_next  = count_inc[CB-1:0];
                        status_next = pvtc_pkg::ST_DIGIT;
                    end
                end
            end
            pvtc_pkg::MODE_VOTE:
            begin
                if (is_cand)
                begin
                    sel_next    = 3'(key_reg - pvtc_pkg::KEY_A) + 3'd1;
                    status_next = pvtc_pkg::ST_SELECTED;
                end
                else if (key_reg == pvtc_pkg::KEY_HASH)
                begin
                    if (sel_reg != 3'd0)
                    begin
                        tally_inc   = 1'b1;
                        status_next = pvtc_pkg::ST_VOTED;
                    end
                    else
                    begin
                        status_next = pvtc_pkg::ST_INVALID;
                    end
                end
                else if (key_reg == pvtc_pkg::KEY_STAR)
                begin
                    entry_next  = '0;
                    count_next  = '0;
                    status_next = pvtc_pkg::ST_ADMIN;
                end
                else
                begin
                    status_next = pvtc_pkg::ST_INVALID;
                end
            end
            pvtc_pkg::MODE_WAIT:
            begin
                if (key_reg == pvtc_pkg::KEY_ONE)
                    status_next = pvtc_pkg::ST_RESTART;
            end
            default:
            begin
                status_next = pvtc_pkg::ST_IGNORED;
            end
        endcase
    end

    // saturating tally update
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            tally_next[i] = tally_reg[i];
            if (tally_inc && sel_idx == 2'(i) && sel_tally != '1)
                tally_next[i] = tally_reg[i] + TALLY_BITS'(1);
            tally_ext[i] = {{TB{1'b0}}, tally_next[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pin_code_reg <= pvtc_pkg::PIN_CODE_RESET;
        else if (pin_code_we)
            pin_code_reg <= pin_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            key_reg <= key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pvtc_pkg::MODE_PIN;
            entry_reg <= '0;
            count_reg <= '0;
            sel_reg   <= '0;
            for (int i = 0; i < 4; i++)
                tally_reg[i] <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            entry_reg <= entry_next;
            count_reg <= count_next;
            sel_reg   <= sel_next;
            for (int i = 0; i < 4; i++)
                tally_reg[i] <= tally_next[i];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= status_next;
            mode_out_reg  <= mode_next;
            count_out_reg <= count_next;
            sel_out_reg   <= sel_next;
            for (int i = 0; i < 4; i++)
                total_reg[i] <= tally_ext[i][TB-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign mode_now       = mode_out_reg;
    assign digits_entered = count_out_reg;
    assign chosen         = sel_out_reg;
    assign total_a        = total_reg[0];
    assign total_b        = total_reg[1];
    assign total_c        = total_reg[2];
    assign total_d        = total_reg[3];

    // a pin entry is only ever in progress while collecting digits
    a_entry_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == pvtc_pkg::MODE_VOTE || mode_reg == pvtc_pkg::MODE_WAIT)
        |-> (count_reg == '0 && entry_reg == '0))
        else $error("pin entry not clear outside digit collection");

    // a vote needs a selection and leads to restart wait
    a_vote_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && status_next == pvtc_pkg::ST_VOTED)
        |-> (sel_reg != 3'd0 && mode_next == pvtc_pkg::MODE_WAIT))
        else $error("vote without selection or wrong next mode");

    // the digit count never reaches the pin length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> ({1'b0, count_reg} < (CB+1)'(PIN_DIGITS)))
        else $error("digit count out of range");

    // a completed word is shown in the result register in the next cycle
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_valid_reg && status_reg == $past(status_next)))
        else $error("result register not loaded");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for the pin locked vote tally controller: scoreboard class, key driver and result monitor

typedef struct packed {
    pvtc_pkg::status_t status;
    pvtc_pkg::mode_t   mode;
    logic [2:0]        digits;
    logic [2:0]        chosen;
    logic [3:0][15:0]  totals;
} tally_word_t;

typedef enum int {
    ENTRY_MORE,
    ENTRY_MATCH,
    ENTRY_MISMATCH
} entry_result_t;

class vote_scoreboard;
    logic [pvtc_pkg::PIN_CODE_BITS-1:0] pin;
    pvtc_pkg::mode_t                    mode;
    logic [pvtc_pkg::PIN_CODE_BITS-1:0] entry;
    int unsigned                        entry_count;
    logic [2:0]                         selection;
    logic [3:0][15:0]                   tally;
    tally_word_t                        expected_words[$];
    int unsigned                        errors;

    function new();
        pin         = pvtc_pkg::PIN_CODE_RESET;
        mode        = pvtc_pkg::MODE_PIN;
        entry       = '0;
        entry_count = 0;
        selection   = '0;
        tally       = '0;
        errors      = 0;
    endfunction

    function entry_result_t take_digit(logic [3:0] d);
        entry_result_t r;
        entry = {entry[pvtc_pkg::PIN_CODE_BITS-5:0], d};
        entry_count++;
        if (entry_count < pvtc_pkg::PIN_DIGITS_DEF)
        begin
            return ENTRY_MORE;
        end
        r           = (entry == pin) ? ENTRY_MATCH : ENTRY_MISMATCH;
        entry       = '0;
        entry_count = 0;
        return r;
    endfunction

    function tally_word_t press_key(logic [3:0] k);
        tally_word_t   w;
        entry_result_t r;
        w.status = pvtc_pkg::ST_IGNORED;
        case (mode)
            pvtc_pkg::MODE_PIN, pvtc_pkg::MODE_ADMIN:
            begin
                if (k <= pvtc_pkg::KEY_LAST_DIGIT)
                begin
                    r = take_digit(k);
                    if (r == ENTRY_MORE)
                    begin
                        w.status = pvtc_pkg::ST_DIGIT;
                    end
                    else if (r == ENTRY_MATCH)
                    begin
                        w.status = (mode == pvtc_pkg::MODE_PIN) ? pvtc_pkg::ST_PIN_OK
                                                                : pvtc_pkg::ST_TOTALS;
                        mode     = (mode == pvtc_pkg::MODE_PIN) ? pvtc_pkg::MODE_VOTE
                                                                : pvtc_pkg::MODE_WAIT;
                    end
                    else
                    begin
                        w.status = pvtc_pkg::ST_PIN_BAD;
                        mode     = (mode == pvtc_pkg::MODE_ADMIN) ? pvtc_pkg::MODE_VOTE
                                                                  : pvtc_pkg::MODE_PIN;
                    end
                end
            end
            pvtc_pkg::MODE_VOTE:
            begin
                if (k >= pvtc_pkg::KEY_A && k <= pvtc_pkg::KEY_D)
                begin
                    selection = 3'(k - pvtc_pkg::KEY_A + 4'd1);
                    w.status  = pvtc_pkg::ST_SELECTED;
                end
                else if (k == pvtc_pkg::KEY_HASH && selection != 3'd0)
                begin
                    if (tally[selection - 3'd1] != 16'hFFFF)
                    begin
                        tally[selection - 3'd1] = tally[selection - 3'd1] + 16'd1;
                    end
                    w.status = pvtc_pkg::ST_VOTED;
                    mode     = pvtc_pkg::MODE_WAIT;
                end
                else if (k == pvtc_pkg::KEY_STAR)
                begin
                    entry       = '0;
                    entry_count = 0;
                    w.status    = pvtc_pkg::ST_ADMIN;
                    mode        = pvtc_pkg::MODE_ADMIN;
                end
                else
                begin
                    w.status = pvtc_pkg::ST_INVALID;
                end
            end
            default:
            begin
                if (k == pvtc_pkg::KEY_ONE)
                begin
                    w.status = pvtc_pkg::ST_RESTART;
                    mode     = pvtc_pkg::MODE_VOTE;
                end
            end
        endcase
        w.mode   = mode;
        w.digits = 3'(entry_count);
        w.chosen = selection;
        w.totals = tally;
        return w;
    endfunction

    function pvtc_pkg::status_t note_key(logic [3:0] k);
        tally_word_t w;
        w = press_key(k);
        expected_words.push_back(w);
        return w.status;
    endfunction

    function void compare(string field, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", field, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_word(logic [3:0] st, logic [1:0] md, logic [2:0] dg, logic [2:0] ch,
                             logic [3:0][15:0] tot);
        tally_word_t w;
        if (expected_words.size() == 0)
        begin
            $error("status word with none expected: status %0d", st);
            errors++;
            return;
        end
        w = expected_words.pop_front();
        compare("status", w.status, st);
        compare("mode_now", w.mode, md);
        compare("digits_entered", w.digits, dg);
        compare("chosen", w.chosen, ch);
        compare("total_a", w.totals[0], tot[0]);
        compare("total_b", w.totals[1], tot[1]);
        compare("total_c", w.totals[2], tot[2]);
        compare("total_d", w.totals[3], tot[3]);
    endfunction
endclass

module tb_top;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RANDOM_WORDS = 1200;
    localparam int FINAL_WORDS  = 250;
    localparam int PHASES       = 6;

    logic                               clk         = 1'b0;
    logic                               rst_n       = 1'b0;
    logic                               pin_code_we = 1'b0;
    logic [pvtc_pkg::PIN_CODE_BITS-1:0] pin_code    = '0;
    logic                               in_valid    = 1'b0;
    logic                               in_ready;
    logic [3:0]                         key         = 4'd0;
    logic                               out_valid;
    logic                               out_ready   = 1'b0;
    logic [3:0]                         status;
    logic [1:0]                         mode_now;
    logic [pvtc_pkg::COUNT_BITS-1:0]    digits_entered;
    logic [2:0]                         chosen;
    logic [pvtc_pkg::TOTAL_BITS-1:0]    total_a;
    logic [pvtc_pkg::TOTAL_BITS-1:0]    total_b;
    logic [pvtc_pkg::TOTAL_BITS-1:0]    total_c;
    logic [pvtc_pkg::TOTAL_BITS-1:0]    total_d;

    vote_scoreboard     sb = new();
    pvtc_pkg::status_t  last_status;
    bit                 idle_on    = 1'b1;
    logic               stall_en   = 1'b1;
    int unsigned        stall_left = 0;
    int unsigned        cycles     = 0;

    pin_locked_vote_tally_controller i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .pin_code_we    (pin_code_we),
        .pin_code       (pin_code),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .key            (key),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .mode_now       (mode_now),
        .digits_entered (digits_entered),
        .chosen         (chosen),
        .total_a        (total_a),
        .total_b        (total_b),
        .total_c        (total_c),
        .total_d        (total_d)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_en && $urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_word(status, mode_now, digits_entered, chosen,
                          {total_d, total_c, total_b, total_a});
        end
    end

    function automatic int unsigned gap_len();
        if (!idle_on || $urandom_range(0, 3) != 0)
        begin
            return 0;
        end
        return $urandom_range(1, 15);
    endfunction

    function automatic logic [3:0] pin_digit(int unsigned pos);
        return sb.pin[4*(pvtc_pkg::PIN_DIGITS_DEF-1-pos) +: 4];
    endfunction

    function automatic logic [pvtc_pkg::PIN_CODE_BITS-1:0] rand_bcd();
        logic [pvtc_pkg::PIN_CODE_BITS-1:0] v;
        for (int i = 0; i < pvtc_pkg::PIN_DIGITS_DEF; i++)
        begin
            v[4*i +: 4] = 4'($urandom_range(0, 9));
        end
        return v;
    endfunction

    // mostly well-formed pin entries and voting sessions, with some noise keys
    function automatic logic [3:0] random_key();
        logic [3:0]  d;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return 4'($urandom_range(0, 15));
        end
        case (sb.mode)
            pvtc_pkg::MODE_PIN, pvtc_pkg::MODE_ADMIN:
            begin
                d = pin_digit(sb.entry_count);
                if (d > pvtc_pkg::KEY_LAST_DIGIT || r < 16)
                begin
                    d = 4'($urandom_range(0, 9));
                end
                return d;
            end
            pvtc_pkg::MODE_VOTE:
            begin
                if (r < 45)
                begin
                    return 4'($urandom_range(pvtc_pkg::KEY_A, pvtc_pkg::KEY_D));
                end
                else if (r < 80)
                begin
                    return pvtc_pkg::KEY_HASH;
                end
                else if (r < 90)
                begin
                    return pvtc_pkg::KEY_STAR;
                end
                return 4'($urandom_range(0, 9));
            end
            default:
            begin
                return (r < 85) ? pvtc_pkg::KEY_ONE : 4'($urandom_range(0, 15));
            end
        endcase
    endfunction

    // drives toward repeated votes for candidate a
    function automatic logic [3:0] sat_key();
        case (sb.mode)
            pvtc_pkg::MODE_PIN, pvtc_pkg::MODE_ADMIN:
            begin
                return pin_digit(sb.entry_count);
            end
            pvtc_pkg::MODE_VOTE:
            begin
                return (sb.selection != 3'd1) ? pvtc_pkg::KEY_A : pvtc_pkg::KEY_HASH;
            end
            default:
            begin
                return pvtc_pkg::KEY_ONE;
            end
        endcase
    endfunction

    task automatic send_key(logic [3:0] k, int unsigned gap);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        key      <= k;
        do @(posedge clk); while (!in_ready);
        last_status = sb.note_key(k);
    endtask

    task automatic write_pin(logic [pvtc_pkg::PIN_CODE_BITS-1:0] value);
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        pin_code_we <= 1'b1;
        pin_code    <= value;
        @(posedge clk);
        pin_code_we <= 1'b0;
        sb.pin = value;
    endtask

    initial
    begin
        logic [3:0]                         opening [$];
        logic [pvtc_pkg::PIN_CODE_BITS-1:0] value;
        int unsigned                        counted;
        int unsigned                        sent;

        opening = '{pvtc_pkg::KEY_STAR, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9,
                    4'd8, 4'd0, 4'd0, 4'd8, 4'd5, pvtc_pkg::KEY_HASH, 4'd0,
                    pvtc_pkg::KEY_D, pvtc_pkg::KEY_HASH, 4'd2, pvtc_pkg::KEY_ONE,
                    pvtc_pkg::KEY_HASH, pvtc_pkg::KEY_ONE,
                    pvtc_pkg::KEY_STAR, 4'd8, 4'd0, 4'd0, 4'd8, 4'd5};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
        begin
            send_key(opening[i], gap_len());
        end

        sent = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: value = '0;
                1: value = '1;
                2: value = 20'h99999;
                3: value = rand_bcd();
                4: value = pvtc_pkg::PIN_CODE_BITS'($urandom);
                default: value = pvtc_pkg::PIN_CODE_RESET;
            endcase
            write_pin(value);
            counted = 0;
            while (counted < RANDOM_WORDS / PHASES)
            begin
                if (sent % 40 == 0)
                begin
                    idle_on = $urandom_range(0, 3) != 0;
                    stall_en <= $urandom_range(0, 3) != 0;
                end
                send_key(random_key(), gap_len());
                sent++;
                if (last_status != pvtc_pkg::ST_IGNORED)
                begin
                    counted++;
                end
            end
        end

        // full speed votes for candidate a, then a totals readout
        idle_on = 1'b0;
        stall_en <= 1'b0;
        write_pin(rand_bcd());
        repeat (FINAL_WORDS) send_key(sat_key(), 0);
        while (sb.mode != pvtc_pkg::MODE_VOTE) send_key(sat_key(), 0);
        send_key(pvtc_pkg::KEY_STAR, 0);
        repeat (pvtc_pkg::PIN_DIGITS_DEF) send_key(sat_key(), 0);

        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
